// ===== hw/rtl/qsc_pkg.sv =====
// Shared widths, register addresses and stage payload types for the quad scissor clip pipeline.
package qsc_pkg;

  localparam int COORD_W = 16;
  localparam int TEX_W   = 16;
  localparam int SPAN_W  = COORD_W + 1;
  localparam int PROD_W  = SPAN_W + TEX_W;
  localparam int QUO_W   = TEX_W;

  localparam logic [1:0] REG_SC_LEFT   = 2'd0;
  localparam logic [1:0] REG_SC_BOTTOM = 2'd1;
  localparam logic [1:0] REG_SC_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SC_HEIGHT = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] cl;
    logic signed [COORD_W-1:0] ct;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] cb;
    logic                      empty;
    logic [SPAN_W-1:0]         w;
    logic [SPAN_W-1:0]         h;
    logic [SPAN_W-1:0]         off_l;
    logic [SPAN_W-1:0]         off_r;
    logic [SPAN_W-1:0]         off_t;
    logic [SPAN_W-1:0]         off_b;
    logic [TEX_W-1:0]          ul;
    logic [TEX_W-1:0]          vb;
    logic [TEX_W-1:0]          us_mag;
    logic [TEX_W-1:0]          vs_mag;
    logic                      us_neg;
    logic                      vs_neg;
  } qsc_clamp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cl;
    logic signed [COORD_W-1:0] ct;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] cb;
    logic                      empty;
    logic [TEX_W-1:0]          ul;
    logic [TEX_W-1:0]          vb;
    logic                      us_neg;
    logic                      vs_neg;
  } qsc_side_t;

endpackage

// ===== hw/rtl/qsc_clamp.sv =====
// First stage: clamp quad edges to the scissor box, form spans, offsets and strides.
module qsc_clamp (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [15:0]            sc_left,
  input  logic signed [15:0]            sc_bottom,
  input  logic [14:0]                   sc_width,
  input  logic [14:0]                   sc_height,
  input  logic signed [15:0]            quad_left,
  input  logic signed [15:0]            quad_top,
  input  logic signed [15:0]            quad_right,
  input  logic signed [15:0]            quad_bottom,
  input  logic [15:0]                   tex_u_left,
  input  logic [15:0]                   tex_u_right,
  input  logic [15:0]                   tex_v_top,
  input  logic [15:0]                   tex_v_bottom,
  output qsc_pkg::qsc_clamp_t           clamp_r
);
  import qsc_pkg::*;

  logic signed [SPAN_W-1:0]  x_far;
  logic signed [SPAN_W-1:0]  y_far;
  logic signed [COORD_W-1:0] cl, ct, cr, cb;
  logic signed [SPAN_W-1:0]  us, vs;
  qsc_clamp_t                clamp_nxt;

  always_comb begin
    x_far = $signed({sc_left[15], sc_left}) + $signed({2'b00, sc_width});
    y_far = $signed({sc_bottom[15], sc_bottom}) + $signed({2'b00, sc_height});
    cl = (quad_left > sc_left) ? quad_left : sc_left;
    cb = (quad_bottom > sc_bottom) ? quad_bottom : sc_bottom;
    cr = (x_far < $signed({quad_right[15], quad_right})) ? x_far[COORD_W-1:0] : quad_right;
    ct = (y_far < $signed({quad_top[15], quad_top})) ? y_far[COORD_W-1:0] : quad_top;
    us = $signed({1'b0, tex_u_right}) - $signed({1'b0, tex_u_left});
    vs = $signed({1'b0, tex_v_top}) - $signed({1'b0, tex_v_bottom});

    clamp_nxt.cl     = cl;
    clamp_nxt.ct     = ct;
    clamp_nxt.cr     = cr;
    clamp_nxt.cb     = cb;
    clamp_nxt.empty  = (cl >= cr) || (ct <= cb);
    clamp_nxt.w      = {quad_right[15], quad_right} - {quad_left[15], quad_left};
    clamp_nxt.h      = {quad_top[15], quad_top} - {quad_bottom[15], quad_bottom};
    clamp_nxt.off_l  = {cl[15], cl} - {quad_left[15], quad_left};
    clamp_nxt.off_r  = {cr[15], cr} - {quad_left[15], quad_left};
    clamp_nxt.off_t  = {ct[15], ct} - {quad_bottom[15], quad_bottom};
    clamp_nxt.off_b  = {cb[15], cb} - {quad_bottom[15], quad_bottom};
    clamp_nxt.ul     = tex_u_left;
    clamp_nxt.vb     = tex_v_bottom;
    clamp_nxt.us_neg = us[SPAN_W-1];
    clamp_nxt.vs_neg = vs[SPAN_W-1];
    clamp_nxt.us_mag = us[SPAN_W-1] ? TEX_W'(-us) : us[TEX_W-1:0];
    clamp_nxt.vs_mag = vs[SPAN_W-1] ? TEX_W'(-vs) : vs[TEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r <= clamp_nxt;
    end
  end

endmodule

// ===== hw/rtl/qsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qsc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qsc_pkg::PROD_W-1:0]  num,
  input  logic [qsc_pkg::SPAN_W-1:0]  den,
  output logic [qsc_pkg::QUO_W-1:0]   quo
);
  import qsc_pkg::*;

  genvar s;
  generate
    for (s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;
      logic [PROD_W-1:0] rem_in;
      logic [SPAN_W-1:0] den_in;
      logic [QUO_W-1:0]  quo_in;
      logic [PROD_W-1:0] dsh;
      logic              take;
      logic [PROD_W-1:0] rem_r;
      logic [SPAN_W-1:0] den_r;
      logic [QUO_W-1:0]  quo_r;

      if (s == 0) begin : g_first
        assign rem_in = num;
        assign den_in = den;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = g_stage[s-1].rem_r;
        assign den_in = g_stage[s-1].den_r;
        assign quo_in = g_stage[s-1].quo_r;
      end

      assign dsh  = PROD_W'(den_in) << BIT;
      assign take = (rem_in >= dsh);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r <= take ? (rem_in - dsh) : rem_in;
          den_r <= den_in;
          quo_r <= quo_in | (QUO_W'(take) << BIT);
        end
      end
    end
  endgenerate

  assign quo = g_stage[QUO_W-1].quo_r;

endmodule

// ===== hw/rtl/quad_scissor_clip_uv_top.sv =====
// Throughput: one word per cycle; a stall on the output holds every stage.
// Stages: one clamp, one multiply, sixteen divider bit stages, one interpolate.
// rst_n (synchronous, active low) clears all valid bits and sets the scissor
// box to origin 0,0 with width and height 32767.
// Top level: scissor clip of one textured quad with texture coordinate interpolation.
module quad_scissor_clip_uv_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // quad_left, quad_top, quad_right, quad_bottom,
  // tex_u_left, tex_u_right, tex_v_top, tex_v_bottom
  input  logic [127:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // clip_left, clip_top, clip_right, clip_bottom,
  // out_u_left, out_u_right, out_v_top, out_v_bottom
  output logic [127:0]  out_tdata,
  // clip_status
  output logic [0:0]    out_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata
);
  import qsc_pkg::*;

  localparam int NSTG = QUO_W + 3;

  logic signed [15:0] sc_left_r, sc_bottom_r;
  logic [14:0]        sc_width_r, sc_height_r;
  logic               en;
  logic [NSTG-1:0]    vld_r;

  qsc_clamp_t         clamp_r;
  qsc_side_t          side_r [QUO_W+1];
  logic [PROD_W-1:0]  p_ul_r, p_ur_r, p_vt_r, p_vb_r;
  logic [SPAN_W-1:0]  w_r, h_r;
  logic [QUO_W-1:0]   q_ul, q_ur, q_vt, q_vb;
  logic [127:0]       tdata_nxt;

  function automatic logic [15:0] interp(input logic [15:0] base, input logic [15:0] q,
                                         input logic neg);
    logic signed [18:0] sum;
    begin
      sum = $signed({3'b000, base}) + (neg ? -$signed({3'b000, q}) : $signed({3'b000, q}));
      if (sum < 0) interp = '0;
      else if (sum > 19'sd65535) interp = 16'hFFFF;
      else interp = sum[15:0];
    end
  endfunction

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_left_r   <= '0;
      sc_bottom_r <= '0;
      sc_width_r  <= 15'h7FFF;
      sc_height_r <= 15'h7FFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SC_LEFT:   sc_left_r   <= cfg_wdata;
        REG_SC_BOTTOM: sc_bottom_r <= cfg_wdata;
        REG_SC_WIDTH:  sc_width_r  <= cfg_wdata[14:0];
        REG_SC_HEIGHT: sc_height_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  qsc_clamp u_clamp (
    .clk          (clk),
    .en           (en),
    .sc_left      (sc_left_r),
    .sc_bottom    (sc_bottom_r),
    .sc_width     (sc_width_r),
    .sc_height    (sc_height_r),
    .quad_left    (in_tdata[15:0]),
    .quad_top     (in_tdata[31:16]),
    .quad_right   (in_tdata[47:32]),
    .quad_bottom  (in_tdata[63:48]),
    .tex_u_left   (in_tdata[79:64]),
    .tex_u_right  (in_tdata[95:80]),
    .tex_v_top    (in_tdata[111:96]),
    .tex_v_bottom (in_tdata[127:112]),
    .clamp_r      (clamp_r)
  );

  // multiply stage; side data rides alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      p_ul_r <= PROD_W'(clamp_r.off_l) * PROD_W'(clamp_r.us_mag);
      p_ur_r <= PROD_W'(clamp_r.off_r) * PROD_W'(clamp_r.us_mag);
      p_vt_r <= PROD_W'(clamp_r.off_t) * PROD_W'(clamp_r.vs_mag);
      p_vb_r <= PROD_W'(clamp_r.off_b) * PROD_W'(clamp_r.vs_mag);
      w_r    <= clamp_r.w;
      h_r    <= clamp_r.h;
      side_r[0] <= '{cl: clamp_r.cl, ct: clamp_r.ct, cr: clamp_r.cr, cb: clamp_r.cb,
                     empty: clamp_r.empty, ul: clamp_r.ul, vb: clamp_r.vb,
                     us_neg: clamp_r.us_neg, vs_neg: clamp_r.vs_neg};
      for (int k = 1; k <= QUO_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  qsc_div u_div_ul (.clk(clk), .en(en), .num(p_ul_r), .den(w_r), .quo(q_ul));
  qsc_div u_div_ur (.clk(clk), .en(en), .num(p_ur_r), .den(w_r), .quo(q_ur));
  qsc_div u_div_vt (.clk(clk), .en(en), .num(p_vt_r), .den(h_r), .quo(q_vt));
  qsc_div u_div_vb (.clk(clk), .en(en), .num(p_vb_r), .den(h_r), .quo(q_vb));

  // drop everything but the flag on an empty clip
  always_comb begin
    if (side_r[QUO_W].empty) begin
      tdata_nxt = '0;
    end else begin
      tdata_nxt = {interp(side_r[QUO_W].vb, q_vb, side_r[QUO_W].vs_neg),
                   interp(side_r[QUO_W].vb, q_vt, side_r[QUO_W].vs_neg),
                   interp(side_r[QUO_W].ul, q_ur, side_r[QUO_W].us_neg),
                   interp(side_r[QUO_W].ul, q_ul, side_r[QUO_W].us_neg),
                   side_r[QUO_W].cb, side_r[QUO_W].cr,
                   side_r[QUO_W].ct, side_r[QUO_W].cl};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= tdata_nxt;
      out_tuser <= side_r[QUO_W].empty;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];

endmodule
